// ===== design/ordb_pkg.sv =====
package ordb_pkg;

	localparam int MAX_OUT    = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;
	localparam int SIZE_W     = 24;
	localparam int PTS_W      = 64;
	localparam int ENTRY_W    = SIZE_W + PTS_W;

	localparam logic [CFG_IDX_W-1:0] CFG_KEEP  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'd1;

	localparam logic [SIZE_W-1:0] SIZE_LIMIT_RST = 24'd2097152;

	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_FLUSH = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam logic [2:0] ST_STORED   = 3'd0;
	localparam logic [2:0] ST_DISABLED = 3'd1;
	localparam logic [2:0] ST_BAD_SIZE = 3'd2;
	localparam logic [2:0] ST_FLUSHED  = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;
	localparam logic [2:0] ST_CLEARED  = 3'd5;

	typedef struct packed {
		logic [1:0]        func;
		logic [SIZE_W-1:0] gop_size;
		logic [PTS_W-1:0]  gop_pts;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [4:0]        slot_index;
		logic [SIZE_W-1:0] entry_size;
		logic [PTS_W-1:0]  entry_pts;
		logic              last;
	} out_item_t;

	typedef struct packed {
		logic       op_write;
		logic       op_single;
		logic [2:0] single_st;
		logic       op_clear;
		logic       walk_start;
		logic       walk_read;
		logic       walk_hit;
		logic       walk_finish;
	} dp_cmd_t;

	typedef struct packed {
		logic lim_zero;
		logic cnt_zero;
		logic size_bad;
		logic out_free;
		logic hit;
		logic walk_more;
		logic pend_valid;
	} dp_stat_t;

endpackage

// ===== design/ordb_ram.sv =====
module ordb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/ordb_dp.sv =====
module ordb_dp #(
	parameter int SLOTS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ordb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ordb_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  ordb_pkg::in_item_t                  in_data,
	input  ordb_pkg::dp_cmd_t                   cmd,
	output ordb_pkg::dp_stat_t                  stat,
	output logic                                out_valid,
	input  logic                                out_stall,
	output ordb_pkg::out_item_t                 out_data
);

	import ordb_pkg::*;

	localparam int PTR_W = $clog2(SLOTS);
	localparam int SUM_W = $clog2(2 * SLOTS);
	localparam int CAP   = (SLOTS < MAX_OUT) ? SLOTS : MAX_OUT;

	logic [5:0]          keep_q;
	logic [SIZE_W-1:0]   limit_q;
	logic [PTR_W-1:0]    wp_q;
	logic [5:0]          cnt_q;
	logic [SLOTS-1:0]    valid_q;
	logic [PTR_W-1:0]    walk_idx_q;
	logic [5:0]          walk_left_q;
	logic                hit_s1;
	logic [PTR_W-1:0]    idx_s1;
	out_item_t           pend_q;
	logic                pend_valid_q;
	out_item_t           out_q;
	logic                out_valid_q;

	logic [5:0]          lim;
	logic                keep_wr;
	logic                empty_ring;
	logic [SUM_W-1:0]    start_sum;
	logic [PTR_W-1:0]    oldest_idx;
	logic [PTR_W-1:0]    wp_next;
	logic [PTR_W-1:0]    walk_next;
	logic [ENTRY_W-1:0]  rdata;
	logic                out_free;
	logic                load_out;
	out_item_t           out_next;
	out_item_t           hit_item;

	assign lim        = (keep_q > 6'(CAP)) ? 6'(CAP) : keep_q;
	assign keep_wr    = cfg_we && (cfg_index == CFG_KEEP);
	assign empty_ring = keep_wr || cmd.op_clear;

	// oldest counted slot: (wp - cnt) mod SLOTS
	assign start_sum = SUM_W'(wp_q) + SUM_W'(SLOTS) - SUM_W'(cnt_q);
	assign oldest_idx = (start_sum >= SUM_W'(SLOTS)) ? PTR_W'(start_sum - SUM_W'(SLOTS))
		: PTR_W'(start_sum);

	assign wp_next   = (wp_q == PTR_W'(SLOTS - 1)) ? '0 : wp_q + 1'b1;
	assign walk_next = (walk_idx_q == PTR_W'(SLOTS - 1)) ? '0 : walk_idx_q + 1'b1;

	ordb_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (cmd.op_write),
		.waddr (wp_q),
		.wdata ({in_data.gop_size, in_data.gop_pts}),
		.re    (cmd.walk_read),
		.raddr (walk_idx_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q  <= '0;
			limit_q <= SIZE_LIMIT_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_KEEP) begin
				keep_q <= cfg_data[5:0];
			end else begin
				limit_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			cnt_q   <= '0;
			valid_q <= '0;
		end else if (empty_ring) begin
			wp_q    <= '0;
			cnt_q   <= '0;
			valid_q <= '0;
		end else begin
			if (cmd.op_write) begin
				valid_q[wp_q] <= 1'b1;
				wp_q          <= wp_next;
				if (cnt_q < lim) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.walk_start) begin
				cnt_q <= '0;
			end
			if (cmd.walk_read) begin
				valid_q[walk_idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_idx_q   <= '0;
			walk_left_q  <= '0;
			hit_s1       <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.walk_start) begin
				walk_idx_q   <= oldest_idx;
				walk_left_q  <= cnt_q;
				pend_valid_q <= 1'b0;
			end
			if (cmd.walk_read) begin
				walk_idx_q  <= walk_next;
				walk_left_q <= walk_left_q - 1'b1;
				hit_s1      <= valid_q[walk_idx_q];
			end
			if (cmd.walk_hit) begin
				pend_valid_q <= 1'b1;
			end
			if (cmd.walk_finish) begin
				pend_valid_q <= 1'b0;
			end
			out_valid_q <= load_out || (out_valid_q && out_stall);
		end
	end

	always_comb begin
		hit_item            = '0;
		hit_item.status     = ST_FLUSHED;
		hit_item.slot_index = 5'(idx_s1);
		hit_item.entry_size = rdata[ENTRY_W-1:PTS_W];
		hit_item.entry_pts  = rdata[PTS_W-1:0];
		hit_item.last       = 1'b0;
	end

	always_comb begin
		out_next = '0;
		load_out = 1'b0;
		if (cmd.op_write) begin
			load_out            = 1'b1;
			out_next.status     = ST_STORED;
			out_next.slot_index = 5'(wp_q);
			out_next.last       = 1'b1;
		end else if (cmd.op_single) begin
			load_out        = 1'b1;
			out_next.status = cmd.single_st;
			out_next.last   = 1'b1;
		end else if (cmd.walk_hit && pend_valid_q) begin
			load_out = 1'b1;
			out_next = pend_q;
		end else if (cmd.walk_finish) begin
			load_out = 1'b1;
			if (pend_valid_q) begin
				out_next      = pend_q;
				out_next.last = 1'b1;
			end else begin
				out_next.status = ST_EMPTY;
				out_next.last   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_read) begin
			idx_s1 <= walk_idx_q;
		end
		if (cmd.walk_hit) begin
			pend_q <= hit_item;
		end
		if (load_out) begin
			out_q <= out_next;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	assign stat.lim_zero   = (lim == '0);
	assign stat.cnt_zero   = (cnt_q == '0);
	assign stat.size_bad   = (in_data.gop_size == '0) || (in_data.gop_size > limit_q);
	assign stat.out_free   = out_free;
	assign stat.hit        = hit_s1;
	assign stat.walk_more  = (walk_left_q != '0);
	assign stat.pend_valid = pend_valid_q;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== design/ordb_ctrl.sv =====
module ordb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         in_func,
	output logic               in_stall,
	input  ordb_pkg::dp_stat_t stat,
	output ordb_pkg::dp_cmd_t  cmd
);

	import ordb_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_EVAL = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_stall = !((state_q == S_IDLE) && stat.out_free);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_func)
						FUNC_WRITE: begin
							if (stat.lim_zero) begin
								cmd.op_single = 1'b1;
								cmd.single_st = ST_DISABLED;
							end else if (stat.size_bad) begin
								cmd.op_single = 1'b1;
								cmd.single_st = ST_BAD_SIZE;
							end else begin
								cmd.op_write = 1'b1;
							end
						end
						FUNC_FLUSH: begin
							if (stat.lim_zero || stat.cnt_zero) begin
								cmd.op_single = 1'b1;
								cmd.single_st = ST_EMPTY;
							end else begin
								cmd.walk_start = 1'b1;
								state_d        = S_READ;
							end
						end
						FUNC_CLEAR: begin
							cmd.op_clear  = 1'b1;
							cmd.op_single = 1'b1;
							cmd.single_st = ST_CLEARED;
						end
						default: begin
						end
					endcase
				end
			end
			S_READ: begin
				cmd.walk_read = 1'b1;
				state_d       = S_EVAL;
			end
			S_EVAL: begin
				// a hit pushes the held entry out first, so wait for room
				if (!stat.hit || !stat.pend_valid || stat.out_free) begin
					cmd.walk_hit = stat.hit;
					state_d      = stat.walk_more ? S_READ : S_FIN;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.walk_finish = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== design/overwrite_ring_descriptor_buffer.sv =====
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+-----------------------------------------
// input    | in_valid  | in_stall  | in_data  (func, gop_size, gop_pts)
// output   | out_valid | out_stall | out_data (status, slot_index, entry_size,
//          |           |           |           entry_pts, last)
// config   | cfg_we    | -         | cfg_index, cfg_data
//
// write, clear and rejected items: one beat per cycle is possible unless stalled
// a flush reads each counted slot from the descriptor ram, oldest first, and
// checks it; a one-entry holding register holds each hit to find the last beat
// after reset the ring is empty, keep_slots is 0 and size_limit is 2097152
// input is taken only when idle and the output register is empty or being drained
// output stalls hold the walk only where it must send a beat; nothing is dropped
module overwrite_ring_descriptor_buffer #(
	parameter int SLOTS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  ordb_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output ordb_pkg::out_item_t             out_data,
	input  logic                            cfg_we,
	input  logic [ordb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ordb_pkg::CFG_DATA_W-1:0] cfg_data
);

	import ordb_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	ordb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_func  (in_data.func),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	ordb_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	a_hit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_hit && stat.pend_valid |-> stat.out_free)
		else $error("held flush entry pushed into a busy output register");

	a_read_eval: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_read |=> !cmd.walk_read)
		else $error("descriptor read issued twice without evaluation");

	a_start_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_start |=> cmd.walk_read)
		else $error("flush walk did not begin with a read");

	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op_write |-> !stat.lim_zero && !stat.size_bad && stat.out_free)
		else $error("store issued while disabled, bad size or output busy");

endmodule
